### src/closest_point_on_polyline_macros.svh
// ----------------------------------------------------------------------------
// Closest point on polyline: assertion macros
// Concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_POLYLINE_MACROS_SVH
`define CLOSEST_POINT_ON_POLYLINE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CPOL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CPOL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define CPOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### src/cpol_pkg.sv
// ----------------------------------------------------------------------------
// cpol_pkg
// Widths, register indexes and formats shared by the polyline block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpol_pkg;

   // Fixed-point format of the coordinates.
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // Width of the coordinate fields on the ports.
   localparam int IO_W = 32;

   // Coordinate width actually used inside the block.
   localparam int CRD_W = (COORD_WIDTH < IO_W) ? COORD_WIDTH : IO_W;

   // Difference of two coordinates.
   localparam int DLT_W = CRD_W + 1;

   // Projection parameter, an unsigned fraction.
   localparam int U_BITS = 2 * FRAC_BITS;
   localparam int CNT_W  = $clog2(U_BITS);

   // Shared multiplier operands and product.
   localparam int MUL_W = (DLT_W > U_BITS + 1) ? DLT_W : U_BITS + 1;
   localparam int PRD_W = 2 * MUL_W;

   // Sum of two squares (unsigned), dot product (signed), division remainder.
   localparam int NRM_W = 2 * CRD_W + 1;
   localparam int DOT_W = 2 * CRD_W + 2;
   localparam int REM_W = NRM_W + 1;

   // Squared distance, saturating.
   localparam int DIST_W = 64;
   localparam int SUMX_W = (NRM_W > DIST_W) ? NRM_W : DIST_W + 1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STATION_X = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATION_Y = 1'd1;

endpackage

`default_nettype wire

### src/cpol_ifs.sv
// ----------------------------------------------------------------------------
// Polyline block channels
// Valid/ready channels for vertex requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpol_req_if import cpol_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IO_W-1:0] vertex_x;
   logic signed [IO_W-1:0] vertex_y;
   logic                   last_vertex;

   modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface cpol_rsp_if import cpol_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IO_W-1:0] closest_x;
   logic signed [IO_W-1:0] closest_y;

   modport source (output valid, closest_x, closest_y, input ready);
   modport sink (input valid, closest_x, closest_y, output ready);
endinterface

interface cpol_csr_if import cpol_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic        [CSR_IDX_W-1:0] index;
   logic signed [IO_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/closest_point_on_polyline.sv
// ----------------------------------------------------------------------------
// closest_point_on_polyline
// Nearest point of a streamed polyline to a station point, Q16.16.
// A first vertex of a polyline goes straight to completion; a lone vertex gives
// its result from there. A segment whose projection is clamped to an end skips
// the radix-2 divider (one quotient bit a cycle) and the offset steps; all paths
// share one multiplier, used eight times on the full path.
// Reset (synchronous) clears the station registers and the polyline state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "closest_point_on_polyline_macros.svh"

module closest_point_on_polyline import cpol_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   cpol_req_if.sink   req_if,
   cpol_rsp_if.source rsp_if,
   cpol_csr_if.sink   csr_if
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
   localparam logic [ST_W-1:0] ST_NRM_A  = 4'd1;
   localparam logic [ST_W-1:0] ST_NRM_B  = 4'd2;
   localparam logic [ST_W-1:0] ST_DOT_A  = 4'd3;
   localparam logic [ST_W-1:0] ST_DOT_B  = 4'd4;
   localparam logic [ST_W-1:0] ST_DOT_C  = 4'd5;
   localparam logic [ST_W-1:0] ST_DECIDE = 4'd6;
   localparam logic [ST_W-1:0] ST_DIV    = 4'd7;
   localparam logic [ST_W-1:0] ST_OFS_A  = 4'd8;
   localparam logic [ST_W-1:0] ST_OFS_B  = 4'd9;
   localparam logic [ST_W-1:0] ST_OFS_C  = 4'd10;
   localparam logic [ST_W-1:0] ST_DST_D  = 4'd11;
   localparam logic [ST_W-1:0] ST_DST_A  = 4'd12;
   localparam logic [ST_W-1:0] ST_DST_B  = 4'd13;
   localparam logic [ST_W-1:0] ST_DST_C  = 4'd14;
   localparam logic [ST_W-1:0] ST_DONE   = 4'd15;

   // Offset along a segment: |delta| * u rounded to the nearest raw unit,
   // ties away from zero, then applied with the sign of the delta.
   function automatic logic signed [CRD_W-1:0] apply_offset(
      input logic signed [CRD_W-1:0] base,
      input logic                    neg,
      input logic signed [PRD_W-1:0] prod
   );
      logic        [PRD_W-1:0] rnd;
      logic        [DLT_W-1:0] mag;
      logic signed [DLT_W-1:0] step;
      logic signed [DLT_W-1:0] sum;
      rnd  = $unsigned(prod) + (PRD_W'(1) << (U_BITS - 1));
      mag  = DLT_W'(rnd >> U_BITS);
      step = neg ? -$signed(mag) : $signed(mag);
      sum  = DLT_W'(base) + step;
      return sum[CRD_W-1:0];
   endfunction

   // Control state
   logic [ST_W-1:0]  state_ff, state_in;
   logic             have_prev_ff, have_prev_in;
   logic             have_best_ff, have_best_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Station registers
   logic signed [IO_W-1:0] station_x_ff, station_x_in;
   logic signed [IO_W-1:0] station_y_ff, station_y_in;

   // Polyline state
   logic signed [CRD_W-1:0] prev_x_ff, prev_x_in;
   logic signed [CRD_W-1:0] prev_y_ff, prev_y_in;
   logic signed [CRD_W-1:0] best_x_ff, best_x_in;
   logic signed [CRD_W-1:0] best_y_ff, best_y_in;
   logic        [DIST_W-1:0] best_dist_ff, best_dist_in;

   // Working registers for one vertex
   logic signed [CRD_W-1:0] cur_x_ff, cur_x_in;
   logic signed [CRD_W-1:0] cur_y_ff, cur_y_in;
   logic                    seg_ff, seg_in;
   logic                    last_ff, last_in;
   logic signed [DLT_W-1:0] abx_ff, abx_in;
   logic signed [DLT_W-1:0] aby_ff, aby_in;
   logic signed [DLT_W-1:0] apx_ff, apx_in;
   logic signed [DLT_W-1:0] apy_ff, apy_in;
   logic        [CRD_W-1:0] mag_x_ff, mag_x_in;
   logic        [CRD_W-1:0] mag_y_ff, mag_y_in;
   logic signed [PRD_W-1:0] prod_ff, prod_in;
   logic signed [PRD_W-1:0] acc_ff, acc_in;
   logic        [NRM_W-1:0] norm_ff, norm_in;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic        [REM_W-1:0] rem_ff, rem_in;
   logic       [U_BITS-1:0] u_ff, u_in;
   logic signed [CRD_W-1:0] cand_x_ff, cand_x_in;
   logic signed [CRD_W-1:0] cand_y_ff, cand_y_in;
   logic signed [DLT_W-1:0] dx_ff, dx_in;
   logic signed [DLT_W-1:0] dy_ff, dy_in;
   logic       [DIST_W-1:0] dist_ff, dist_in;

   // Result register
   logic signed [IO_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [IO_W-1:0] rsp_y_ff, rsp_y_in;

   // Datapath
   logic signed [CRD_W-1:0] px, py, vx, vy;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PRD_W-1:0] pair_sum;
   logic       [SUMX_W-1:0] sum_ext;
   logic        [REM_W-1:0] rem_sh;
   logic                    rem_ge;
   logic                    req_fire;
   logic                    slot_free;
   logic                    take;
   logic signed [CRD_W-1:0] new_best_x, new_best_y;

   assign px = $signed(station_x_ff[CRD_W-1:0]);
   assign py = $signed(station_y_ff[CRD_W-1:0]);
   assign vx = $signed(req_if.vertex_x[CRD_W-1:0]);
   assign vy = $signed(req_if.vertex_y[CRD_W-1:0]);

   assign req_if.ready    = (state_ff == ST_IDLE);
   assign req_fire        = req_if.valid && req_if.ready;
   assign csr_if.ready    = 1'b1;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.closest_x = rsp_x_ff;
   assign rsp_if.closest_y = rsp_y_ff;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   // Shared multiplier operand selection.
   always_comb begin
      unique case (state_ff)
         ST_NRM_A: begin
            mul_a = MUL_W'(abx_ff);
            mul_b = MUL_W'(abx_ff);
         end
         ST_NRM_B: begin
            mul_a = MUL_W'(aby_ff);
            mul_b = MUL_W'(aby_ff);
         end
         ST_DOT_A: begin
            mul_a = MUL_W'(apx_ff);
            mul_b = MUL_W'(abx_ff);
         end
         ST_DOT_B: begin
            mul_a = MUL_W'(apy_ff);
            mul_b = MUL_W'(aby_ff);
         end
         ST_OFS_A: begin
            mul_a = MUL_W'($signed({1'b0, mag_x_ff}));
            mul_b = MUL_W'($signed({1'b0, u_ff}));
         end
         ST_OFS_B: begin
            mul_a = MUL_W'($signed({1'b0, mag_y_ff}));
            mul_b = MUL_W'($signed({1'b0, u_ff}));
         end
         ST_DST_A: begin
            mul_a = MUL_W'(dx_ff);
            mul_b = MUL_W'(dx_ff);
         end
         ST_DST_B: begin
            mul_a = MUL_W'(dy_ff);
            mul_b = MUL_W'(dy_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign pair_sum = acc_ff + prod_ff;
   assign sum_ext  = SUMX_W'(pair_sum[NRM_W-1:0]);

   assign rem_sh = {rem_ff[REM_W-2:0], 1'b0};
   assign rem_ge = (rem_sh >= REM_W'(norm_ff));

   // The first segment always wins; later ones only when strictly nearer.
   assign take       = !have_best_ff || (dist_ff < best_dist_ff);
   assign new_best_x = !seg_ff ? cur_x_ff : (take ? cand_x_ff : best_x_ff);
   assign new_best_y = !seg_ff ? cur_y_ff : (take ? cand_y_ff : best_y_ff);

   always_comb begin
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      have_best_in = have_best_ff;
      cnt_in       = cnt_ff;
      station_x_in = station_x_ff;
      station_y_in = station_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      best_dist_in = best_dist_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      seg_in       = seg_ff;
      last_in      = last_ff;
      abx_in       = abx_ff;
      aby_in       = aby_ff;
      apx_in       = apx_ff;
      apy_in       = apy_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      acc_in       = acc_ff;
      norm_in      = norm_ff;
      dot_in       = dot_ff;
      rem_in       = rem_ff;
      u_in         = u_ff;
      cand_x_in    = cand_x_ff;
      cand_y_in    = cand_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dist_in      = dist_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_STATION_X: station_x_in = csr_if.data;
            CSR_STATION_Y: station_y_in = csr_if.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_x_in = vx;
               cur_y_in = vy;
               last_in  = req_if.last_vertex;
               seg_in   = have_prev_ff;
               abx_in   = DLT_W'(vx) - DLT_W'(prev_x_ff);
               aby_in   = DLT_W'(vy) - DLT_W'(prev_y_ff);
               apx_in   = DLT_W'(px) - DLT_W'(prev_x_ff);
               apy_in   = DLT_W'(py) - DLT_W'(prev_y_ff);
               state_in = have_prev_ff ? ST_NRM_A : ST_DONE;
            end
         end
         ST_NRM_A: state_in = ST_NRM_B;
         ST_NRM_B: begin
            acc_in   = prod_ff;
            state_in = ST_DOT_A;
         end
         ST_DOT_A: begin
            norm_in  = pair_sum[NRM_W-1:0];
            state_in = ST_DOT_B;
         end
         ST_DOT_B: begin
            acc_in   = prod_ff;
            state_in = ST_DOT_C;
         end
         ST_DOT_C: begin
            dot_in   = pair_sum[DOT_W-1:0];
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // Zero-length segment or projection behind the start: start point.
            if ((norm_ff == '0) || dot_ff[DOT_W-1]) begin
               cand_x_in = prev_x_ff;
               cand_y_in = prev_y_ff;
               state_in  = ST_DST_D;
            end else if (dot_ff[DOT_W-1:0] >= DOT_W'(norm_ff)) begin
               cand_x_in = cur_x_ff;
               cand_y_in = cur_y_ff;
               state_in  = ST_DST_D;
            end else begin
               rem_in   = REM_W'(dot_ff[DOT_W-1:0]);
               u_in     = '0;
               cnt_in   = CNT_W'(U_BITS - 1);
               mag_x_in = CRD_W'(abx_ff[DLT_W-1] ? -abx_ff : abx_ff);
               mag_y_in = CRD_W'(aby_ff[DLT_W-1] ? -aby_ff : aby_ff);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? (rem_sh - REM_W'(norm_ff)) : rem_sh;
            u_in   = {u_ff[U_BITS-2:0], rem_ge};
            if (cnt_ff == '0) begin
               state_in = ST_OFS_A;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_OFS_A: state_in = ST_OFS_B;
         ST_OFS_B: begin
            cand_x_in = apply_offset(prev_x_ff, abx_ff[DLT_W-1], prod_ff);
            state_in  = ST_OFS_C;
         end
         ST_OFS_C: begin
            cand_y_in = apply_offset(prev_y_ff, aby_ff[DLT_W-1], prod_ff);
            state_in  = ST_DST_D;
         end
         ST_DST_D: begin
            dx_in    = DLT_W'(px) - DLT_W'(cand_x_ff);
            dy_in    = DLT_W'(py) - DLT_W'(cand_y_ff);
            state_in = ST_DST_A;
         end
         ST_DST_A: state_in = ST_DST_B;
         ST_DST_B: begin
            acc_in   = prod_ff;
            state_in = ST_DST_C;
         end
         ST_DST_C: begin
            dist_in  = (|sum_ext[SUMX_W-1:DIST_W]) ? '1 : sum_ext[DIST_W-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // A last vertex waits here until the result register is free.
            if (!last_ff || slot_free) begin
               best_x_in    = new_best_x;
               best_y_in    = new_best_y;
               if (seg_ff && take) begin
                  best_dist_in = dist_ff;
                  have_best_in = 1'b1;
               end
               prev_x_in    = cur_x_ff;
               prev_y_in    = cur_y_ff;
               have_prev_in = 1'b1;
               state_in     = ST_IDLE;
               if (last_ff) begin
                  rsp_x_in     = IO_W'(new_best_x);
                  rsp_y_in     = IO_W'(new_best_y);
                  rsp_valid_in = 1'b1;
                  prev_x_in    = '0;
                  prev_y_in    = '0;
                  have_prev_in = 1'b0;
                  best_x_in    = '0;
                  best_y_in    = '0;
                  best_dist_in = '1;
                  have_best_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         station_x_ff <= '0;
         station_y_ff <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         best_dist_ff <= '1;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         station_x_ff <= station_x_in;
         station_y_ff <= station_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         best_x_ff    <= best_x_in;
         best_y_ff    <= best_y_in;
         best_dist_ff <= best_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      seg_ff    <= seg_in;
      last_ff   <= last_in;
      abx_ff    <= abx_in;
      aby_ff    <= aby_in;
      apx_ff    <= apx_in;
      apy_ff    <= apy_in;
      mag_x_ff  <= mag_x_in;
      mag_y_ff  <= mag_y_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      norm_ff   <= norm_in;
      dot_ff    <= dot_in;
      rem_ff    <= rem_in;
      u_ff      <= u_in;
      cand_x_ff <= cand_x_in;
      cand_y_ff <= cand_y_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dist_ff   <= dist_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
   end

   // A new result only ever comes out of the final step of a last vertex.
   `CPOL_ASSERT_IMPLY(a_rsp_origin, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_DONE && last_ff), "result raised outside a last vertex")

   // The division remainder stays below the divisor on every iteration.
   `CPOL_ASSERT_IMPLY(a_rem_bound, clock, reset, state_ff == ST_DIV,
      rem_ff < REM_W'(norm_ff), "division remainder out of range")

   // A vertex with no predecessor skips the arithmetic entirely.
   `CPOL_ASSERT_NEXT(a_first_vertex, clock, reset, req_fire && !have_prev_ff,
      state_ff == ST_DONE, "first vertex did not go straight to completion")

endmodule

`default_nettype wire
